/* hdl/ardq_pkg.sv */
// Shared types and constants for the ack/retry dispatch queue.
// Used by every module of the block but ardq_ram; depends on nothing.
package ardq_pkg;

  localparam int TAG_W      = 16;
  localparam int TICK_W     = 16;
  localparam int RETRY_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int QLIM_W     = 5;
  localparam int CNT_OUT_W  = 5;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd3000;
  localparam logic [TICK_W-1:0] TICK_SAT      = 16'hFFFF;

  // input function codes
  localparam logic [1:0] FUNC_SUBMIT = 2'd0;
  localparam logic [1:0] FUNC_STATE  = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  // device states
  localparam logic [1:0] DEV_IDLE   = 2'd0;
  localparam logic [1:0] DEV_LISTEN = 2'd1;
  localparam logic [1:0] DEV_SPEAK  = 2'd2;

  // submit status codes
  localparam logic [1:0] STAT_NONE     = 2'd0;
  localparam logic [1:0] STAT_QUEUED   = 2'd1;
  localparam logic [1:0] STAT_REJECTED = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QLIMIT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd2;

  localparam int CMDQ_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_SUBMIT,
    OP_EMPTY,
    OP_STATE,
    OP_TICK
  } op_e;

  typedef enum logic {
    BK_EXEC,
    BK_FETCH
  } back_state_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [TAG_W-1:0] item_tag;
    logic             item_empty;
    logic [1:0]       device_state;
  } in_t;

  typedef struct packed {
    logic                 send_valid;
    logic [TAG_W-1:0]     send_tag;
    logic                 send_is_retry;
    logic [1:0]           submit_status;
    logic [CNT_OUT_W-1:0] dropped_oldest;
    logic                 item_abandoned;
    logic [CNT_OUT_W-1:0] queue_count;
    logic                 busy_res;
    logic                 awaiting_ack;
  } out_t;

  typedef struct packed {
    op_e              op;
    logic [TAG_W-1:0] tag;
    logic [1:0]       dev;
  } cmd_t;

endpackage

/* hdl/ack_retry_dispatch_queue.sv */
// Ack/retry dispatch queue, top level.
// Depends on ardq_pkg, ardq_front, ardq_cmd_fifo, ardq_back.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries submit, device
// state and tick items. Every accepted item yields exactly one result on the
// output channel (out_valid_o / out_stall_i / out_data_o), in order.
// The front end classifies items into a two-entry command queue; the back end
// owns the tag queue, the single in-flight send and the result register.
// An accepted item is registered in the command queue, then its result in the
// result register; an item that takes a tag out of the queue also passes the
// fetch state for the tag store read port.
// Throughput: one item per cycle unless the receiver stalls or a tag fetch runs.
// The cfg port (cfg_we_i, cfg_idx_i, cfg_data_i) writes the queue limit, the
// drop-on-full mode and the ack timeout, one register per cycle; write only
// while idle.
// Reset empties the queue, clears the in-flight item, sets the device state to
// idle and restores the register defaults. When the receiver stalls, the
// result holds; up to two more items are taken into the command queue, then
// in_stall_o rises.
module ack_retry_dispatch_queue #(
  parameter int DEPTH       = 16,
  parameter int MAX_RETRIES = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ardq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ardq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  ardq_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ardq_pkg::out_t                  out_data_o
);

  logic           push, full, cmd_valid, cmd_pop;
  ardq_pkg::cmd_t push_cmd, head_cmd;

  ardq_front u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .push_o    (push),
    .cmd_o     (push_cmd),
    .full_i    (full)
  );

  ardq_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .full_o     (full),
    .valid_o    (cmd_valid),
    .data_o     (head_cmd),
    .pop_i      (cmd_pop)
  );

  ardq_back #(
    .DEPTH      (DEPTH),
    .MAX_RETRIES(MAX_RETRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (head_cmd),
    .cmd_pop_o  (cmd_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

/* hdl/ardq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ardq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hdl/ardq_front.sv */
// Front end: takes input items and classifies them into commands.
// Depends on ardq_pkg.
module ardq_front (
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ardq_pkg::in_t  in_data_i,
  output logic           push_o,
  output ardq_pkg::cmd_t cmd_o,
  input  logic           full_i
);

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cmd_o.tag = in_data_i.item_tag;
    cmd_o.dev = in_data_i.device_state;
    unique case (in_data_i.func)
      ardq_pkg::FUNC_SUBMIT: begin
        cmd_o.op = in_data_i.item_empty ? ardq_pkg::OP_EMPTY : ardq_pkg::OP_SUBMIT;
      end
      ardq_pkg::FUNC_STATE: cmd_o.op = ardq_pkg::OP_STATE;
      ardq_pkg::FUNC_TICK:  cmd_o.op = ardq_pkg::OP_TICK;
      default:              cmd_o.op = ardq_pkg::OP_NOP;
    endcase
  end

endmodule

/* hdl/ardq_cmd_fifo.sv */
// Two-entry command queue between front and back ends.
// Depends on ardq_pkg.
module ardq_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ardq_pkg::cmd_t push_data_i,
  output logic           full_o,
  output logic           valid_o,
  output ardq_pkg::cmd_t data_o,
  input  logic           pop_i
);

  localparam int PW = $clog2(ardq_pkg::CMDQ_DEPTH);
  localparam int NW = $clog2(ardq_pkg::CMDQ_DEPTH + 1);

  ardq_pkg::cmd_t slot_q [ardq_pkg::CMDQ_DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]  fill_q;

  assign full_o  = (fill_q == NW'(ardq_pkg::CMDQ_DEPTH));
  assign valid_o = (fill_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(ardq_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(ardq_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

/* hdl/ardq_back.sv */
// Back end: tag queue, send controller, config registers and result register.
// Depends on ardq_pkg and ardq_ram.
module ardq_back #(
  parameter int DEPTH       = 16,
  parameter int MAX_RETRIES = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ardq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ardq_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               cmd_valid_i,
  input  ardq_pkg::cmd_t                     cmd_i,
  output logic                               cmd_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output ardq_pkg::out_t                     out_data_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int XW = (CW > ardq_pkg::CNT_OUT_W) ? CW : ardq_pkg::CNT_OUT_W;
  localparam int TW = ardq_pkg::TAG_W;
  localparam int KW = ardq_pkg::TICK_W;
  localparam int RW = ardq_pkg::RETRY_W;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
    return r[AW-1:0];
  endfunction

  function automatic logic [ardq_pkg::CNT_OUT_W-1:0] to_out(input logic [CW-1:0] v);
    logic [XW-1:0] x;
    x = XW'(v);
    return x[ardq_pkg::CNT_OUT_W-1:0];
  endfunction

  // config
  logic [ardq_pkg::QLIM_W-1:0] qlim_q;
  logic                        drop_q;
  logic [KW-1:0]               tmo_q;

  // controller state
  ardq_pkg::back_state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          busy_q, busy_d;
  logic          ack_q, ack_d;
  logic [TW-1:0] cur_tag_q, cur_tag_d;
  logic [RW-1:0] retry_q, retry_d;
  logic [KW-1:0] wait_q, wait_d;
  logic [1:0]    last_q, last_d;
  logic          byp_q, byp_d;
  logic [TW-1:0] byp_tag_q, byp_tag_d;
  ardq_pkg::out_t out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [TW-1:0] ram_rdata;

  logic          go;
  logic [XW-1:0] lim_x;
  logic [CW-1:0] lim;
  logic [CW-1:0] dropped;
  logic          ok, try_en, disp, resend, abandon;
  logic [1:0]    try_st, status, prev;
  logic [KW-1:0] wait_inc;
  ardq_pkg::out_t res;

  ardq_ram #(
    .WIDTH(TW),
    .DEPTH(DEPTH)
  ) u_tag_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(cmd_i.tag),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign go          = (state_q == ardq_pkg::BK_EXEC) && cmd_valid_i &&
                       (!out_valid_q || !out_stall_i);
  assign cmd_pop_o   = go;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a limit of zero or above the store depth means the whole store
  assign lim_x = ((qlim_q == '0) || (XW'(qlim_q) > XW'(DEPTH))) ? XW'(DEPTH) : XW'(qlim_q);
  assign lim   = lim_x[CW-1:0];

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    busy_d      = busy_q;
    ack_d       = ack_q;
    cur_tag_d   = cur_tag_q;
    retry_d     = retry_q;
    wait_d      = wait_q;
    last_d      = last_q;
    byp_d       = byp_q;
    byp_tag_d   = byp_tag_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = '0;
    ram_raddr   = head_q;
    dropped     = '0;
    ok          = 1'b1;
    try_en      = 1'b0;
    try_st      = last_q;
    disp        = 1'b0;
    resend      = 1'b0;
    abandon     = 1'b0;
    status      = ardq_pkg::STAT_NONE;
    prev        = last_q;
    wait_inc    = (wait_q < ardq_pkg::TICK_SAT) ? wait_q + 1'b1 : wait_q;
    res         = '0;

    if (go) begin
      unique case (cmd_i.op)
        ardq_pkg::OP_EMPTY: status = ardq_pkg::STAT_EMPTY;
        ardq_pkg::OP_SUBMIT: begin
          if (count_q >= lim) begin
            if (drop_q) begin
              dropped = count_q - lim + 1'b1;
              head_d  = wrap(SW'(head_q) + SW'(dropped));
              count_d = count_q - dropped;
            end else begin
              ok = 1'b0;
            end
          end
          if (ok) begin
            ram_we    = 1'b1;
            ram_waddr = wrap(SW'(head_d) + SW'(count_d));
            byp_d     = (count_d == '0);  // new tag goes straight out
            byp_tag_d = cmd_i.tag;
            count_d   = count_d + 1'b1;
            status    = ardq_pkg::STAT_QUEUED;
            try_en    = 1'b1;
          end else begin
            status = ardq_pkg::STAT_REJECTED;
          end
        end
        ardq_pkg::OP_STATE: begin
          last_d = cmd_i.dev;
          if (cmd_i.dev == ardq_pkg::DEV_SPEAK && busy_q && ack_q) begin
            ack_d  = 1'b0;
            wait_d = '0;
          end
          if (prev == ardq_pkg::DEV_SPEAK &&
              (cmd_i.dev == ardq_pkg::DEV_IDLE || cmd_i.dev == ardq_pkg::DEV_LISTEN)) begin
            if (busy_q) begin
              busy_d  = 1'b0;
              ack_d   = 1'b0;
              retry_d = '0;
              wait_d  = '0;
            end
            try_en = 1'b1;
            try_st = cmd_i.dev;
            byp_d  = 1'b0;
          end
        end
        ardq_pkg::OP_TICK: begin
          if (busy_q && ack_q) begin
            if (wait_inc >= tmo_q) begin
              wait_d = '0;
              if (RW'(retry_q) < RW'(MAX_RETRIES)) begin
                retry_d = retry_q + 1'b1;
                resend  = 1'b1;
              end else begin
                busy_d  = 1'b0;
                ack_d   = 1'b0;
                abandon = 1'b1;
                try_en  = 1'b1;
                byp_d   = 1'b0;
              end
            end else begin
              wait_d = wait_inc;
            end
          end
        end
        default: ;
      endcase

      if (try_en && (try_st == ardq_pkg::DEV_IDLE || try_st == ardq_pkg::DEV_LISTEN) &&
          !busy_d && count_d != '0) begin
        disp      = 1'b1;
        ram_re    = 1'b1;
        ram_raddr = head_d;
        head_d    = wrap(SW'(head_d) + SW'(1));
        count_d   = count_d - 1'b1;
        busy_d    = 1'b1;
        ack_d     = 1'b1;
        retry_d   = '0;
        wait_d    = '0;
      end

      res.send_valid     = resend;
      res.send_tag       = resend ? cur_tag_q : '0;
      res.send_is_retry  = resend;
      res.submit_status  = status;
      res.dropped_oldest = to_out(dropped);
      res.item_abandoned = abandon;
      res.queue_count    = to_out(count_d);
      res.busy_res       = busy_d;
      res.awaiting_ack   = ack_d;
      out_d              = res;
      if (disp) begin
        // the send tag arrives from the store, or the bypass register, next cycle
        out_valid_d = 1'b0;
        state_d     = ardq_pkg::BK_FETCH;
      end else begin
        out_valid_d = 1'b1;
      end
    end else if (state_q == ardq_pkg::BK_FETCH) begin
      cur_tag_d           = byp_q ? byp_tag_q : ram_rdata;
      out_d.send_valid    = 1'b1;
      out_d.send_tag      = cur_tag_d;
      out_d.send_is_retry = 1'b0;
      out_valid_d         = 1'b1;
      state_d             = ardq_pkg::BK_EXEC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlim_q      <= '0;
      drop_q      <= 1'b1;
      tmo_q       <= ardq_pkg::TIMEOUT_RESET;
      state_q     <= ardq_pkg::BK_EXEC;
      head_q      <= '0;
      count_q     <= '0;
      busy_q      <= 1'b0;
      ack_q       <= 1'b0;
      cur_tag_q   <= '0;
      retry_q     <= '0;
      wait_q      <= '0;
      last_q      <= ardq_pkg::DEV_IDLE;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ardq_pkg::CFG_QLIMIT:      qlim_q <= cfg_data_i[ardq_pkg::QLIM_W-1:0];
          ardq_pkg::CFG_DROP_MODE:   drop_q <= cfg_data_i[0];
          ardq_pkg::CFG_ACK_TIMEOUT: tmo_q  <= cfg_data_i[KW-1:0];
          default: ;
        endcase
      end
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      busy_q      <= busy_d;
      ack_q       <= ack_d;
      cur_tag_q   <= cur_tag_d;
      retry_q     <= retry_d;
      wait_q      <= wait_d;
      last_q      <= last_d;
      byp_q       <= byp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_tag_q <= byp_tag_d;
    out_q     <= out_d;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("tag queue count above depth");

  a_ack_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ack_q |-> busy_q)
    else $error("awaiting ack with nothing in flight");

  a_fetch_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ardq_pkg::BK_FETCH) |-> !out_valid_q)
    else $error("result register busy during store fetch");

  a_fetch_sends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ardq_pkg::BK_FETCH) |=> (out_valid_q && out_q.send_valid && busy_q))
    else $error("store fetch did not produce a send");
`endif

endmodule

/* sim/ack_retry_dispatch_queue_tb.sv */
// Self-checking testbench for ack_retry_dispatch_queue: directed and random items,
// a cycle-free predictor in a scoreboard class, random input gaps and output stalls.
// Depends on ardq_pkg and the block's RTL.
module ack_retry_dispatch_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 16;
  localparam int MAX_RETRIES = 1;
  localparam int HOLD_CYCLES = 120;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 180;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] DEV_OTHER   = 2'd3;

  // Scoreboard: mirrors the queue and the send controller, holds expected results.
  class dispatch_scoreboard #(int QDEPTH = 16, int RETRY_MAX = 1);
    ardq_pkg::out_t expected_q[$];
    int             errors;
    int             seen;
    logic [4:0]     limit_reg;
    bit             drop_reg;
    logic [15:0]    timeout_reg;
    logic [15:0]    tag_mem[QDEPTH];
    int unsigned    head;
    int unsigned    count;
    bit             busy;
    bit             unacked;
    logic [15:0]    cur_tag;
    int unsigned    retries;
    logic [15:0]    ticks;
    logic [1:0]     dev_seen;
    ardq_pkg::out_t res;

    function new();
      errors      = 0;
      seen        = 0;
      limit_reg   = '0;
      drop_reg    = 1'b1;
      timeout_reg = ardq_pkg::TIMEOUT_RESET;
      head        = 0;
      count       = 0;
      busy        = 1'b0;
      unacked     = 1'b0;
      cur_tag     = '0;
      retries     = 0;
      ticks       = '0;
      dev_seen    = ardq_pkg::DEV_IDLE;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(logic [ardq_pkg::CFG_IDX_W-1:0] idx,
                          logic [ardq_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        ardq_pkg::CFG_QLIMIT:      limit_reg = val[4:0];
        ardq_pkg::CFG_DROP_MODE:   drop_reg = val[0];
        ardq_pkg::CFG_ACK_TIMEOUT: timeout_reg = val;
        default: ;
      endcase
    endfunction

    // Pop the head tag into flight when the device allows it.
    function void launch(logic [1:0] st);
      if (st != ardq_pkg::DEV_IDLE && st != ardq_pkg::DEV_LISTEN) return;
      if (busy || count == 0) return;
      cur_tag = tag_mem[head];
      head    = (head + 1) % QDEPTH;
      count--;
      busy    = 1'b1;
      unacked = 1'b1;
      retries = 0;
      ticks   = '0;
      res.send_valid    = 1'b1;
      res.send_tag      = cur_tag;
      res.send_is_retry = 1'b0;
    endfunction

    function void note_input(ardq_pkg::in_t it);
      int unsigned lim;
      int unsigned dropped;
      bit          ok;
      logic [1:0]  prev;
      res = '0;
      case (it.func)
        ardq_pkg::FUNC_SUBMIT: begin
          if (it.item_empty) begin
            res.submit_status = ardq_pkg::STAT_EMPTY;
          end else begin
            lim = limit_reg;
            if (lim == 0 || lim > QDEPTH) lim = QDEPTH;
            ok = 1'b1;
            if (count >= lim) begin
              if (drop_reg) begin
                dropped = count - lim + 1;
                head    = (head + dropped) % QDEPTH;
                count   = count - dropped;
                res.dropped_oldest = 5'(dropped);
              end else begin
                ok = 1'b0;
              end
            end
            if (ok) begin
              tag_mem[(head + count) % QDEPTH] = it.item_tag;
              count++;
              res.submit_status = ardq_pkg::STAT_QUEUED;
              launch(dev_seen);
            end else begin
              res.submit_status = ardq_pkg::STAT_REJECTED;
            end
          end
        end
        ardq_pkg::FUNC_STATE: begin
          prev     = dev_seen;
          dev_seen = it.device_state;
          if (it.device_state == ardq_pkg::DEV_SPEAK && busy && unacked) begin
            unacked = 1'b0;
            ticks   = '0;
          end
          // leaving speaking finishes the in-flight item
          if (prev == ardq_pkg::DEV_SPEAK &&
              (it.device_state == ardq_pkg::DEV_IDLE ||
               it.device_state == ardq_pkg::DEV_LISTEN)) begin
            if (busy) begin
              busy    = 1'b0;
              unacked = 1'b0;
              retries = 0;
              ticks   = '0;
            end
            launch(it.device_state);
          end
        end
        ardq_pkg::FUNC_TICK: begin
          if (busy && unacked) begin
            if (ticks != ardq_pkg::TICK_SAT) ticks++;
            if (ticks >= timeout_reg) begin
              ticks = '0;
              if (retries < RETRY_MAX) begin
                retries++;
                res.send_valid    = 1'b1;
                res.send_tag      = cur_tag;
                res.send_is_retry = 1'b1;
              end else begin
                busy    = 1'b0;
                unacked = 1'b0;
                res.item_abandoned = 1'b1;
                launch(dev_seen);
              end
            end
          end
        end
        default: ;
      endcase
      res.queue_count  = 5'(count);
      res.busy_res     = busy;
      res.awaiting_ack = unacked;
      expected_q.insert(expected_q.size(), res);
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    task check_result(ardq_pkg::out_t got);
      ardq_pkg::out_t exp;
      string          bad;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected: %h", got));
        return;
      end
      exp = expected_q[0];
      expected_q.delete(0);
      bad = "";
      if (got.send_valid     !== exp.send_valid)     bad = {bad, " send_valid"};
      if (got.send_tag       !== exp.send_tag)       bad = {bad, " send_tag"};
      if (got.send_is_retry  !== exp.send_is_retry)  bad = {bad, " send_is_retry"};
      if (got.submit_status  !== exp.submit_status)  bad = {bad, " submit_status"};
      if (got.dropped_oldest !== exp.dropped_oldest) bad = {bad, " dropped_oldest"};
      if (got.item_abandoned !== exp.item_abandoned) bad = {bad, " item_abandoned"};
      if (got.queue_count    !== exp.queue_count)    bad = {bad, " queue_count"};
      if (got.busy_res       !== exp.busy_res)       bad = {bad, " busy_res"};
      if (got.awaiting_ack   !== exp.awaiting_ack)   bad = {bad, " awaiting_ack"};
      if (bad != "")
        report($sformatf("result %0d:%s (got %h exp %h)", seen, bad, got, exp));
      seen++;
    endtask
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [ardq_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [ardq_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  ardq_pkg::in_t                   in_data;
  logic                            out_valid;
  logic                            out_stall;
  ardq_pkg::out_t                  out_data;

  bit quiet;
  bit long_hold_req;

  dispatch_scoreboard #(DEPTH, MAX_RETRIES) sb;

  always #1 clk_i = ~clk_i;

  ack_retry_dispatch_queue #(
    .DEPTH       (DEPTH),
    .MAX_RETRIES (MAX_RETRIES)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  function automatic ardq_pkg::in_t mk(logic [1:0] f, logic [15:0] t, logic e,
                                       logic [1:0] d);
    ardq_pkg::in_t it;
    it.func         = f;
    it.item_tag     = t;
    it.item_empty   = e;
    it.device_state = d;
    return it;
  endfunction

  // Mostly submit / speak / leave-speaking / tick traffic, a little unused func.
  function automatic ardq_pkg::in_t rand_item();
    ardq_pkg::in_t it;
    int            r;
    it.func         = FUNC_UNUSED;
    it.item_tag     = 16'($urandom);
    it.item_empty   = 1'($urandom_range(1));
    it.device_state = 2'($urandom_range(3));
    r = $urandom_range(99);
    if (r < 38) begin
      it.func       = ardq_pkg::FUNC_SUBMIT;
      it.item_empty = ($urandom_range(19) == 0);
    end else if (r < 62) begin
      it.func = ardq_pkg::FUNC_STATE;
      r = $urandom_range(99);
      it.device_state = (r < 40) ? ardq_pkg::DEV_SPEAK : (r < 65) ? ardq_pkg::DEV_IDLE :
                        (r < 90) ? ardq_pkg::DEV_LISTEN : DEV_OTHER;
    end else if (r < 95) begin
      it.func = ardq_pkg::FUNC_TICK;
    end
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic drive_item(ardq_pkg::in_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_input(it);
  endtask

  // Stop offering items and wait until every expected result has come.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(logic [4:0] lim, bit drop, logic [15:0] timeout);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= ardq_pkg::CFG_QLIMIT;
    cfg_data <= 16'(lim);
    @(posedge clk_i);
    cfg_idx  <= ardq_pkg::CFG_DROP_MODE;
    cfg_data <= 16'(drop);
    @(posedge clk_i);
    cfg_idx  <= ardq_pkg::CFG_ACK_TIMEOUT;
    cfg_data <= timeout;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_reg(ardq_pkg::CFG_QLIMIT, 16'(lim));
    sb.set_reg(ardq_pkg::CFG_DROP_MODE, 16'(drop));
    sb.set_reg(ardq_pkg::CFG_ACK_TIMEOUT, timeout);
    @(posedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int r;
    forever begin
      r = $urandom_range(99);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (quiet || r < 65) begin
        out_stall <= 1'b0;
        @(posedge clk_i);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(8, 40)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    #2000000;
    $display("ack_retry_dispatch_queue_tb: errors");
    $finish;
  end

  initial begin
    logic [4:0]  lim;
    bit          drop;
    logic [15:0] timeout;
    sb = new();
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    rst_ni   <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: full depth, drop oldest, long timeout
    drive_item(mk(ardq_pkg::FUNC_SUBMIT, 16'hFFFF, 1'b1, DEV_OTHER));  // empty ignored
    drive_item(mk(ardq_pkg::FUNC_STATE, 16'hA5A5, 1'b1, DEV_OTHER));
    drive_item(mk(ardq_pkg::FUNC_SUBMIT, 16'h0000, 1'b0, ardq_pkg::DEV_IDLE));  // queued
    drive_item(mk(ardq_pkg::FUNC_SUBMIT, 16'hFFFF, 1'b0, ardq_pkg::DEV_SPEAK));
    drive_item(mk(FUNC_UNUSED, 16'h5A5A, 1'b1, ardq_pkg::DEV_SPEAK));
    drive_item(mk(ardq_pkg::FUNC_TICK, 16'h1234, 1'b0, ardq_pkg::DEV_IDLE));  // nothing out
    drive_item(mk(ardq_pkg::FUNC_STATE, 16'h0000, 1'b0, ardq_pkg::DEV_SPEAK));
    drive_item(mk(ardq_pkg::FUNC_STATE, 16'hFFFF, 1'b0, ardq_pkg::DEV_IDLE));  // send
    drive_item(mk(ardq_pkg::FUNC_TICK, 16'h0000, 1'b0, DEV_OTHER));
    drive_item(mk(ardq_pkg::FUNC_STATE, 16'h0000, 1'b0, ardq_pkg::DEV_SPEAK));  // ack
    drive_item(mk(ardq_pkg::FUNC_TICK, 16'hFFFF, 1'b1, DEV_OTHER));  // acked: no effect
    drive_item(mk(ardq_pkg::FUNC_STATE, 16'h0000, 1'b0, ardq_pkg::DEV_LISTEN));

    // tiny limit, reject when full, zero timeout
    configure(5'd2, 1'b0, 16'd0);
    drive_item(mk(ardq_pkg::FUNC_STATE, 16'h0000, 1'b0, ardq_pkg::DEV_SPEAK));
    drive_item(mk(ardq_pkg::FUNC_STATE, 16'h0000, 1'b0, DEV_OTHER));
    drive_item(mk(ardq_pkg::FUNC_SUBMIT, 16'h1111, 1'b0, DEV_OTHER));
    drive_item(mk(ardq_pkg::FUNC_SUBMIT, 16'h2222, 1'b0, DEV_OTHER));
    drive_item(mk(ardq_pkg::FUNC_SUBMIT, 16'h3333, 1'b0, DEV_OTHER));   // rejected
    drive_item(mk(ardq_pkg::FUNC_STATE, 16'h0000, 1'b0, ardq_pkg::DEV_SPEAK));
    drive_item(mk(ardq_pkg::FUNC_STATE, 16'h0000, 1'b0, ardq_pkg::DEV_IDLE));
    drive_item(mk(ardq_pkg::FUNC_TICK, 16'h0000, 1'b0, ardq_pkg::DEV_IDLE));  // retry
    drive_item(mk(ardq_pkg::FUNC_TICK, 16'h0000, 1'b0, ardq_pkg::DEV_IDLE));  // abandon

    // fill, then lower the limit below the fill level
    configure(5'd16, 1'b1, 16'd1);
    drive_item(mk(ardq_pkg::FUNC_STATE, 16'h0000, 1'b0, DEV_OTHER));
    drive_item(mk(ardq_pkg::FUNC_SUBMIT, 16'h4444, 1'b0, DEV_OTHER));
    drive_item(mk(ardq_pkg::FUNC_SUBMIT, 16'h5555, 1'b0, DEV_OTHER));
    drive_item(mk(ardq_pkg::FUNC_SUBMIT, 16'h6666, 1'b0, DEV_OTHER));
    drive_item(mk(ardq_pkg::FUNC_SUBMIT, 16'h7777, 1'b0, DEV_OTHER));
    configure(5'd2, 1'b1, 16'd1);
    drive_item(mk(ardq_pkg::FUNC_SUBMIT, 16'h8888, 1'b0, DEV_OTHER));   // drops three
    drive_item(mk(ardq_pkg::FUNC_TICK, 16'h0000, 1'b0, DEV_OTHER));
    drive_item(mk(ardq_pkg::FUNC_TICK, 16'h0000, 1'b0, DEV_OTHER));

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin lim = 5'd16; drop = 1'b1; timeout = 16'd1;     end
        1: begin lim = 5'd1;  drop = 1'b0; timeout = 16'd2;     end
        2: begin lim = 5'd0;  drop = 1'b1; timeout = 16'hFFFF;  end
        3: begin lim = 5'd31; drop = 1'b0; timeout = 16'd4;     end
        4: begin lim = 5'd3;  drop = 1'b1; timeout = 16'd0;     end
        default: begin
          lim     = 5'($urandom_range(31));
          drop    = 1'($urandom_range(1));
          timeout = 16'($urandom_range(1, 6));
        end
      endcase
      configure(lim, drop, timeout);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        quiet = (k >= 100 && k < 130) || (ph == 2 && k >= 20 && k < 50);
        if (ph == 2 && k == 20) long_hold_req = 1'b1;
        if (k == 60) settle();
        drive_item(rand_item());
      end
      quiet = 1'b0;
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("ack_retry_dispatch_queue_tb: clean");
    end else begin
      $display("ack_retry_dispatch_queue_tb: errors");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/ardq_pkg.sv
hdl/ardq_ram.sv
hdl/ardq_front.sv
hdl/ardq_cmd_fifo.sv
hdl/ardq_back.sv
hdl/ack_retry_dispatch_queue.sv
sim/ack_retry_dispatch_queue_tb.sv
